// ===== rtl/nnk_pkg.sv =====
package nnk_pkg;

    localparam int IDX_W  = 16;
    localparam int DIST_W = 32;
    localparam int K_W    = 5;
    localparam int RANK_W = 4;
    localparam int APB_AW = 2;
    localparam int APB_DW = 32;

    localparam logic [APB_AW-1:0] ADDR_NEIGHBOUR_COUNT = APB_AW'(0);
    localparam logic [K_W-1:0]    NEIGHBOUR_COUNT_RST  = K_W'(4);

    typedef struct packed {
        logic [IDX_W-1:0]  candidate_index;
        logic [DIST_W-1:0] candidate_distance;
        logic [IDX_W-1:0]  query_index;
        logic              last_candidate;
    } t_cand;

    typedef struct packed {
        logic [IDX_W-1:0]  neighbour_index;
        logic [DIST_W-1:0] neighbour_distance;
        logic [RANK_W-1:0] neighbour_rank;
        logic [K_W-1:0]    found_count;
        logic              last_result;
    } t_nbr;

    // what a cell shows its neighbors
    typedef struct packed {
        logic              valid;
        logic              lt;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] distance;
    } t_link;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic              start;
        logic              clip;
        logic              insert;
        logic              shift_out;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] distance;
        logic [K_W-1:0]    k;
    } t_cell_cmd;

endpackage

// ===== rtl/nnk_if.sv =====
interface nnk_cand_if;
    import nnk_pkg::*;
    logic  valid;
    logic  ready;
    t_cand data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface nnk_nbr_if;
    import nnk_pkg::*;
    logic valid;
    logic ready;
    t_nbr data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/nnk_cell.sv =====
module nnk_cell #(
    parameter int CELL_ID = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nnk_pkg::t_cell_cmd i_cmd,
    input  nnk_pkg::t_link     i_prev,
    input  nnk_pkg::t_link     i_next,
    input  logic               i_tok,
    input  logic               i_hit,
    output nnk_pkg::t_link     o_link,
    output logic               o_tok,
    output logic               o_hit
);
    import nnk_pkg::*;

    logic              r_valid;
    logic [IDX_W-1:0]  r_idx;
    logic [DIST_W-1:0] r_dist;
    logic              r_tok;
    logic              r_hit;

    logic w_eq;
    logic w_lt;
    logic w_in_k;
    logic w_at_end;
    logic w_ins;

    assign w_eq     = r_valid && (r_idx == i_cmd.idx);
    assign w_lt     = r_valid && (i_cmd.distance < r_dist);
    assign w_in_k   = (32'(CELL_ID) < 32'(i_cmd.k));
    assign w_at_end = !r_valid && i_prev.valid;
    assign w_ins    = i_cmd.insert && w_in_k;

    assign o_link = '{valid: r_valid, lt: w_lt, idx: r_idx, distance: r_dist};
    assign o_tok  = r_tok;
    assign o_hit  = r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.clip) begin
            r_valid <= r_valid && w_in_k;
        end else if (w_ins) begin
            if (i_prev.lt || w_lt || w_at_end) begin
                r_valid <= 1'b1;
            end
        end else if (i_cmd.shift_out) begin
            r_valid <= i_next.valid;
        end
    end

    // entries at or after the insertion point move one cell toward the tail; shift-out moves each one toward the head
    always_ff @(posedge i_clk) begin
        if (w_ins && !i_cmd.clip) begin
            if (i_prev.lt) begin
                r_idx  <= i_prev.idx;
                r_dist <= i_prev.distance;
            end else if (w_lt || w_at_end) begin
                r_idx  <= i_cmd.idx;
                r_dist <= i_cmd.distance;
            end
        end else if (i_cmd.shift_out && !i_cmd.clip) begin
            r_idx  <= i_next.idx;
            r_dist <= i_next.distance;
        end
    end

    // duplicate search token ripples one cell per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            r_tok <= i_tok;
            r_hit <= i_hit || (i_tok && w_eq);
        end
    end

endmodule

// ===== rtl/nnk_cfg.sv =====
module nnk_cfg #(
    parameter int MAX_NEIGHBOURS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [nnk_pkg::APB_AW-1:0] paddr,
    input  logic [nnk_pkg::APB_DW-1:0] pwdata,
    output logic [nnk_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output logic [nnk_pkg::K_W-1:0]    o_k
);
    import nnk_pkg::*;

    logic [K_W-1:0] r_neighbour_count;
    logic           w_sel;

    assign w_sel  = (paddr == ADDR_NEIGHBOUR_COUNT);
    assign pready = 1'b1;
    assign prdata = w_sel ? APB_DW'(r_neighbour_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neighbour_count <= NEIGHBOUR_COUNT_RST;
        end else if (psel && penable && pwrite && w_sel) begin
            r_neighbour_count <= pwdata[K_W-1:0];
        end
    end

    // zero acts as one, anything above the cell count as the cell count
    always_comb begin
        if (r_neighbour_count == '0) begin
            o_k = K_W'(1);
        end else if (32'(r_neighbour_count) > 32'(MAX_NEIGHBOURS)) begin
            o_k = K_W'(MAX_NEIGHBOURS);
        end else begin
            o_k = r_neighbour_count;
        end
    end

endmodule

// ===== rtl/nearest_neighbour_top_k.sv =====
// Candidate that is not skipped: once accepted, the duplicate-search token crosses
// the cells, then it is inserted unless a duplicate was found; no new candidate is
// taken before the token reaches the tail.
// Skipped candidate (self or beyond library): accepted with no search or insert.
// After a last candidate the list drains max(found, 1) beats, one per cycle while the output is not stalled.
// Reset (synchronous, active low) empties the list and sets neighbour_count to 4;
// the output valid and the search token are cleared as well.
module nearest_neighbour_top_k #(
    parameter int MAX_NEIGHBOURS = 16,
    parameter int LIBRARY_SIZE   = 65536
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    nnk_cand_if.sink                   i_cand,
    nnk_nbr_if.source                  o_nbr,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [nnk_pkg::APB_AW-1:0] paddr,
    input  logic [nnk_pkg::APB_DW-1:0] pwdata,
    output logic [nnk_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import nnk_pkg::*;

    localparam int FILL_W = $clog2(MAX_NEIGHBOURS + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_EMIT  = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [IDX_W-1:0]  r_cand_idx;
    logic [DIST_W-1:0] r_cand_dist;
    logic              r_cand_last;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] r_rank;
    logic              r_out_valid;
    t_nbr              r_out;

    logic [K_W-1:0]    w_k;
    logic [FILL_W-1:0] w_k_f;
    logic [FILL_W-1:0] w_fill_clip;
    logic              w_acc;
    logic              w_skip;
    logic              w_load;
    logic              w_emit_last;
    logic              w_tail_tok;
    logic              w_tail_hit;
    t_cell_cmd         w_cmd;

    t_link             w_link [MAX_NEIGHBOURS];
    t_link             w_prev [MAX_NEIGHBOURS];
    t_link             w_next [MAX_NEIGHBOURS];
    logic [MAX_NEIGHBOURS-1:0] w_tok;
    logic [MAX_NEIGHBOURS-1:0] w_hit;
    logic [MAX_NEIGHBOURS-1:0] w_tok_in;
    logic [MAX_NEIGHBOURS-1:0] w_hit_in;

    nnk_cfg #(
        .MAX_NEIGHBOURS(MAX_NEIGHBOURS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_k     (w_k)
    );

    assign w_k_f       = FILL_W'(w_k);
    assign w_fill_clip = (r_fill > w_k_f) ? w_k_f : r_fill;

    assign i_cand.ready = (r_state == S_IDLE);
    assign w_acc        = i_cand.valid && (r_state == S_IDLE);
    assign w_skip       = (i_cand.data.candidate_index == i_cand.data.query_index) ||
                          !(32'(i_cand.data.candidate_index) < 32'(LIBRARY_SIZE));

    assign w_tail_tok = w_tok[MAX_NEIGHBOURS-1];
    assign w_tail_hit = w_hit[MAX_NEIGHBOURS-1];

    assign w_load      = (r_state == S_EMIT) && (!r_out_valid || o_nbr.ready);
    assign w_emit_last = (r_fill == '0) || ((r_rank + FILL_W'(1)) == r_fill);

    always_comb begin
        w_cmd.start     = w_acc && !w_skip;
        w_cmd.clip      = w_acc;
        w_cmd.insert    = (r_state == S_CHECK) && w_tail_tok && !w_tail_hit;
        w_cmd.shift_out = w_load && (r_fill != '0);
        w_cmd.idx       = (r_state == S_IDLE) ? i_cand.data.candidate_index : r_cand_idx;
        w_cmd.distance  = r_cand_dist;
        w_cmd.k         = w_k;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_NEIGHBOURS; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign w_prev[g]   = '{valid: 1'b1, lt: 1'b0, idx: '0, distance: '0};
                assign w_tok_in[g] = w_cmd.start;
                assign w_hit_in[g] = 1'b0;
            end else begin : g_body
                assign w_prev[g]   = w_link[g-1];
                assign w_tok_in[g] = w_tok[g-1];
                assign w_hit_in[g] = w_hit[g-1];
            end
            if (g == MAX_NEIGHBOURS - 1) begin : g_tail
                assign w_next[g] = '{valid: 1'b0, lt: 1'b0, idx: '0, distance: '0};
            end else begin : g_mid
                assign w_next[g] = w_link[g+1];
            end

            nnk_cell #(
                .CELL_ID(g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd),
                .i_prev  (w_prev[g]),
                .i_next  (w_next[g]),
                .i_tok   (w_tok_in[g]),
                .i_hit   (w_hit_in[g]),
                .o_link  (w_link[g]),
                .o_tok   (w_tok[g]),
                .o_hit   (w_hit[g])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (!w_skip) begin
                        n_state = S_CHECK;
                    end else if (i_cand.data.last_candidate) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_CHECK: begin
                if (w_tail_tok) begin
                    n_state = r_cand_last ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (w_load && w_emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_rank      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_acc) begin
                r_fill <= w_fill_clip;
            end else if (w_cmd.insert && (r_fill < w_k_f)) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (w_load && w_emit_last) begin
                r_fill <= '0;
            end
            if (w_load) begin
                r_rank      <= w_emit_last ? '0 : r_rank + FILL_W'(1);
                r_out_valid <= 1'b1;
            end else if (o_nbr.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cand_idx  <= i_cand.data.candidate_index;
            r_cand_dist <= i_cand.data.candidate_distance;
            r_cand_last <= i_cand.data.last_candidate;
        end
        if (w_load) begin
            // an empty list still reports one beat with zeros
            r_out.neighbour_index    <= (r_fill == '0) ? '0 : w_link[0].idx;
            r_out.neighbour_distance <= (r_fill == '0) ? '0 : w_link[0].distance;
            r_out.neighbour_rank     <= RANK_W'(r_rank);
            r_out.found_count        <= K_W'(r_fill);
            r_out.last_result        <= w_emit_last;
        end
    end

    assign o_nbr.valid = r_out_valid;
    assign o_nbr.data  = r_out;

endmodule

// ===== rtl/nnk_checker.sv =====
module nnk_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input logic          i_in_last,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input nnk_pkg::t_nbr i_out_data
);
    import nnk_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result beat changed while stalled");

    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.found_count == '0) |->
            i_out_data.last_result && (i_out_data.neighbour_rank == '0) &&
            (i_out_data.neighbour_index == '0) && (i_out_data.neighbour_distance == '0))
        else $error("empty-list beat malformed");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_last |=> !$rose(i_out_valid))
        else $error("result started by a non-final candidate");

    a_busy_while_draining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.last_result |-> !i_in_ready)
        else $error("candidate taken while list still draining");

endmodule

bind nearest_neighbour_top_k nnk_checker u_nnk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cand.valid),
    .i_in_ready  (i_cand.ready),
    .i_in_last   (i_cand.data.last_candidate),
    .i_out_valid (o_nbr.valid),
    .i_out_ready (o_nbr.ready),
    .i_out_data  (o_nbr.data)
);
